[rtl/btr_pkg.sv]
// Package for the button telegram repeater.
// Field widths, phase codes, register indexes, reset values and decode types.
package btr_pkg;

  localparam int BUTTON_W   = 8;
  localparam int SECONDS_W  = 16;
  localparam int MILLIS_W   = 8;
  localparam int KIND_W     = 2;
  localparam int ADDR_W     = 8;
  localparam int NUM_PAIRS  = 4;
  localparam int PAIR_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // phase codes
  localparam logic [1:0] PHASE_IDLE    = 2'd0;
  localparam logic [1:0] PHASE_SENDING = 2'd1;
  localparam logic [1:0] PHASE_TIMEOUT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAIR0_ADDR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR1_ADDR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR2_ADDR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR3_ADDR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_S      = 3'd5;

  localparam logic [MILLIS_W-1:0]  INTERVAL_RESET = 8'd48;
  localparam logic [SECONDS_W-1:0] LIMIT_RESET    = 16'd8;

  typedef struct packed {
    logic              pressed;
    logic [KIND_W-1:0] kind;
    logic [PAIR_W-1:0] pair;
  } press_t;

endpackage

[rtl/btr_in_if.sv]
// Input channel of the button telegram repeater: one button scan per request.
// Depends on btr_pkg for field widths.
interface btr_in_if;
  logic                           valid;
  logic                           ready;
  logic [btr_pkg::BUTTON_W-1:0]   button_bits;
  logic [btr_pkg::SECONDS_W-1:0]  now_seconds;
  logic [btr_pkg::MILLIS_W-1:0]   now_millis;

  modport source (output valid, button_bits, now_seconds, now_millis, input ready);
  modport sink   (input valid, button_bits, now_seconds, now_millis, output ready);
endinterface

[rtl/btr_out_if.sv]
// Result channel of the button telegram repeater: one telegram per request.
// Depends on btr_pkg for field widths.
interface btr_out_if;
  logic                         valid;
  logic                         ready;
  logic [btr_pkg::KIND_W-1:0]   press_kind;
  logic [btr_pkg::ADDR_W-1:0]   sender_address;

  modport source (output valid, press_kind, sender_address, input ready);
  modport sink   (input valid, press_kind, sender_address, output ready);
endinterface

[rtl/btr_decode.sv]
// Button register decoder: finds the single active adjacent pair and its kind.
// Depends on btr_pkg for press_t and widths.
module btr_decode (
  input  logic [btr_pkg::BUTTON_W-1:0] button_bits,
  output btr_pkg::press_t              press
);
  import btr_pkg::*;

  always_comb begin
    press = '0;
    for (int p = 0; p < NUM_PAIRS; p++) begin
      logic [BUTTON_W-1:0] mask;
      logic [1:0]          v;
      mask = BUTTON_W'(2'b11) << (2 * p);
      v    = button_bits[2*p +: 2];
      // valid press: nothing outside this pair, something inside it
      if (((button_bits & ~mask) == '0) && (v != 2'b00)) begin
        press.pressed = 1'b1;
        press.kind    = v - 2'd1;
        press.pair    = PAIR_W'(p);
      end
    end
  end

endmodule

[rtl/button_telegram_repeat.sv]
// Top level of the button telegram repeater: scan register, phase control,
// result register. Depends on btr_pkg, btr_in_if, btr_out_if and btr_decode.
//
//   channel  direction  payload                                  handshake
//   in_ch    sink       button_bits, now_seconds, now_millis     valid/ready
//   out_ch   source     press_kind, sender_address               valid/ready
//   cfg_*    sink       cfg_index, cfg_wdata                     cfg_we
//
// One scan per cycle unless a held result stalls an emitting scan; a scan sits in the
// scan register after the accepting edge, and its telegram is loaded into the result
// register when the scan leaves the scan register, and leaves the block from there.
// The phase and timestamp registers update when the scan leaves the scan register.
// A held result stalls only a scan that itself emits; silent scans keep flowing.
// Synchronous active-low reset: idle phase, empty registers, config defaults.
module button_telegram_repeat (
  input  logic                            clk,
  input  logic                            rst_n,
  btr_in_if.sink                          in_ch,
  btr_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [btr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [btr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import btr_pkg::*;

  // configuration
  logic [ADDR_W-1:0]    pair_addr_r [NUM_PAIRS];
  logic [MILLIS_W-1:0]  interval_r;
  logic [SECONDS_W-1:0] limit_r;

  // scan register
  logic                 s1_valid_r;
  logic [BUTTON_W-1:0]  s1_bits_r;
  logic [SECONDS_W-1:0] s1_sec_r;
  logic [MILLIS_W-1:0]  s1_ms_r;

  // state
  logic [1:0]           phase_r, phase_nxt;
  logic [SECONDS_W-1:0] start_sec_r, start_sec_nxt;
  logic [MILLIS_W-1:0]  last_ms_r, last_ms_nxt;

  // result register
  logic                 out_valid_r;
  logic [KIND_W-1:0]    out_kind_r;
  logic [ADDR_W-1:0]    out_addr_r;

  press_t               press;
  logic                 emit;
  logic                 out_free;
  logic                 s1_go;
  logic                 s1_fire;
  logic                 in_fire;
  logic [SECONDS_W-1:0] sec_delta;
  logic [MILLIS_W-1:0]  ms_delta;

  btr_decode u_decode (
    .button_bits (s1_bits_r),
    .press       (press)
  );

  assign sec_delta = s1_sec_r - start_sec_r;
  assign ms_delta  = s1_ms_r - last_ms_r;

  always_comb begin
    phase_nxt     = phase_r;
    start_sec_nxt = start_sec_r;
    last_ms_nxt   = last_ms_r;
    emit          = 1'b0;
    unique case (phase_r)
      PHASE_IDLE: begin
        if (press.pressed) begin
          start_sec_nxt = s1_sec_r;
          last_ms_nxt   = s1_ms_r;
          emit          = 1'b1;
          phase_nxt     = PHASE_SENDING;
        end
      end
      PHASE_SENDING: begin
        if (!press.pressed) begin
          phase_nxt = PHASE_IDLE;
        end else if (sec_delta < limit_r) begin
          if (ms_delta >= interval_r) begin
            last_ms_nxt = s1_ms_r;
            emit        = 1'b1;
          end
        end else begin
          phase_nxt = PHASE_TIMEOUT;
        end
      end
      PHASE_TIMEOUT: begin
        if (!press.pressed) phase_nxt = PHASE_IDLE;
      end
      default: begin
        phase_nxt = PHASE_IDLE;
      end
    endcase
  end

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_go       = !emit || out_free;
  assign s1_fire     = s1_valid_r && s1_go;
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PAIRS; i++) pair_addr_r[i] <= '0;
      interval_r <= INTERVAL_RESET;
      limit_r    <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAIR0_ADDR:  pair_addr_r[0] <= cfg_wdata[ADDR_W-1:0];
        REG_PAIR1_ADDR:  pair_addr_r[1] <= cfg_wdata[ADDR_W-1:0];
        REG_PAIR2_ADDR:  pair_addr_r[2] <= cfg_wdata[ADDR_W-1:0];
        REG_PAIR3_ADDR:  pair_addr_r[3] <= cfg_wdata[ADDR_W-1:0];
        REG_INTERVAL_MS: interval_r     <= cfg_wdata[MILLIS_W-1:0];
        REG_LIMIT_S:     limit_r        <= cfg_wdata[SECONDS_W-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // scan register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_bits_r <= in_ch.button_bits;
      s1_sec_r  <= in_ch.now_seconds;
      s1_ms_r   <= in_ch.now_millis;
    end
  end

  // phase and timestamps advance once per scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PHASE_IDLE;
      start_sec_r <= '0;
      last_ms_r   <= '0;
    end else if (s1_fire) begin
      phase_r     <= phase_nxt;
      start_sec_r <= start_sec_nxt;
      last_ms_r   <= last_ms_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      out_kind_r <= press.kind;
      out_addr_r <= pair_addr_r[press.pair];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.press_kind     = out_kind_r;
  assign out_ch.sender_address = out_addr_r;

  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && emit |=> out_valid_r)
    else $error("emitted telegram did not reach the result register");

  a_first_press_sends: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (phase_r == PHASE_IDLE) && press.pressed |=> phase_r == PHASE_SENDING)
    else $error("first press did not enter sending");

  a_no_idle_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (phase_r == PHASE_IDLE) |=> phase_r != PHASE_TIMEOUT)
    else $error("idle jumped straight to timed out");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r && emit && out_valid_r && !out_ch.ready)
    else $error("input stalled without a blocked telegram");

  a_timeout_silent: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && (phase_r == PHASE_TIMEOUT) |-> !emit)
    else $error("telegram emitted while timed out");

endmodule
